[src/binary_max_heap_queue_unit_assert.svh]
// Assertion macros for the binary max-heap queue unit.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bmhq_pkg.sv]
// Shared constants and types for the binary max-heap queue unit.
// No dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 128;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = 8;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_LD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CH,
    ST_DN_SW,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[src/bmhq_ram.sv]
// Generic RAM: one write port and two read ports, read data registered.
// No dependencies.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[src/binary_max_heap_queue_unit.sv]
// A refused request goes straight to ST_OUT. A push climbs one level per ST_UP_RD,
// ST_UP_CMP pass and stops at the root or below a parent at least as large; a pop loads root
// and last entry in ST_POP_LD, then sinks one level per ST_DN_RD, ST_DN_CH, ST_DN_SW pass.
// A busy output holds the result back. One request at a time, taken only in idle; one
// shared RAM and comparator, one level per read-compare-write pass. Reset clears the entry
// count and output valid; the heap RAM is not cleared and needs no clearing pass.
`default_nettype none

module binary_max_heap_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] popped_value, [39:32] count
  output logic [2:0]  m_axis_tuser    // [0] pop_valid, [2:1] error
);

  localparam int SW = bmhq_pkg::SLOT_W;
  localparam int AW = bmhq_pkg::ADDR_W;
  localparam int KW = bmhq_pkg::KEY_W;

  bmhq_pkg::state_t state, state_next;
  logic [SW-1:0]    count_q, count_next;
  logic [SW-1:0]    slot_idx, slot_next;
  logic [SW-1:0]    child_slot, child_slot_next;
  logic [KW-1:0]    key, key_next;
  logic [KW-1:0]    child_val, child_val_next;
  logic [KW-1:0]    res_value, res_value_next;
  logic             res_pop, res_pop_next;
  bmhq_pkg::err_t   res_err, res_err_next;
  logic             out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [KW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [KW-1:0] cmp_a, cmp_b;
  logic          cmp_less;

  logic [SW:0]   left_slot, right_slot, count_ext;
  logic          left_ok, right_ok;
  logic [SW-1:0] parent_slot;
  logic [AW-1:0] slot_addr, parent_addr, left_addr, right_addr, last_addr;
  logic          in_req;

  bmhq_ram #(
    .WIDTH(KW),
    .DEPTH(bmhq_pkg::CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .rdata_a(ram_rdata_a),
    .raddr_b(ram_raddr_b),
    .rdata_b(ram_rdata_b)
  );

  // Slot arithmetic: slots are one-based, RAM addresses are slot - 1.
  assign count_ext   = {1'b0, count_q};
  assign left_slot   = {slot_idx, 1'b0};
  assign right_slot  = {slot_idx, 1'b1};
  assign left_ok     = left_slot <= count_ext;
  assign right_ok    = right_slot <= count_ext;
  assign parent_slot = slot_idx >> 1;
  assign slot_addr   = AW'(slot_idx - SW'(1));
  assign parent_addr = AW'(parent_slot - SW'(1));
  assign left_addr   = AW'(left_slot - (SW+1)'(1));
  assign right_addr  = right_ok ? AW'(left_slot) : left_addr;
  assign last_addr   = AW'(count_q - SW'(1));

  // The one shared key comparator.
  assign cmp_less = $signed(cmp_a) < $signed(cmp_b);

  assign s_axis_tready = (state == bmhq_pkg::ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == bmhq_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next      = state;
    count_next      = count_q;
    slot_next       = slot_idx;
    child_slot_next = child_slot;
    key_next        = key;
    child_val_next  = child_val;
    res_value_next  = res_value;
    res_pop_next    = res_pop;
    res_err_next    = res_err;
    ram_we          = 1'b0;
    ram_waddr       = slot_addr;
    ram_wdata       = key;
    ram_raddr_a     = '0;
    ram_raddr_b     = last_addr;
    cmp_a           = key;
    cmp_b           = child_val;

    case (state)
      bmhq_pkg::ST_IDLE: begin
        // Root and last entry are read speculatively for a pop.
        if (in_req) begin
          res_value_next = '0;
          res_pop_next   = 1'b0;
          res_err_next   = bmhq_pkg::ERR_NONE;
          if (s_axis_tuser == bmhq_pkg::ACT_PUSH) begin
            if (count_q == SW'(bmhq_pkg::CAPACITY)) begin
              res_err_next = bmhq_pkg::ERR_FULL;
              state_next   = bmhq_pkg::ST_OUT;
            end else begin
              count_next = count_q + SW'(1);
              slot_next  = count_q + SW'(1);
              key_next   = s_axis_tdata;
              state_next = bmhq_pkg::ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_err_next = bmhq_pkg::ERR_EMPTY;
              state_next   = bmhq_pkg::ST_OUT;
            end else begin
              state_next = bmhq_pkg::ST_POP_LD;
            end
          end
        end
      end
      bmhq_pkg::ST_POP_LD: begin
        res_value_next = ram_rdata_a;
        res_pop_next   = 1'b1;
        key_next       = ram_rdata_b;
        count_next     = count_q - SW'(1);
        slot_next      = SW'(1);
        state_next     = bmhq_pkg::ST_DN_RD;
      end
      bmhq_pkg::ST_UP_RD: begin
        ram_raddr_a = parent_addr;
        if (slot_idx == SW'(1)) begin
          ram_we     = 1'b1;
          state_next = bmhq_pkg::ST_OUT;
        end else begin
          state_next = bmhq_pkg::ST_UP_CMP;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        cmp_a = ram_rdata_a;
        cmp_b = key;
        ram_we = 1'b1;
        if (cmp_less) begin
          // Parent moves down, key climbs one level.
          ram_wdata  = ram_rdata_a;
          slot_next  = parent_slot;
          state_next = bmhq_pkg::ST_UP_RD;
        end else begin
          state_next = bmhq_pkg::ST_OUT;
        end
      end
      bmhq_pkg::ST_DN_RD: begin
        ram_raddr_a = left_addr;
        ram_raddr_b = right_addr;
        if (!left_ok) begin
          ram_we     = 1'b1;
          state_next = bmhq_pkg::ST_OUT;
        end else begin
          state_next = bmhq_pkg::ST_DN_CH;
        end
      end
      bmhq_pkg::ST_DN_CH: begin
        // Pick the larger child; a tie keeps the left one.
        cmp_a = ram_rdata_a;
        cmp_b = ram_rdata_b;
        if (right_ok && cmp_less) begin
          child_slot_next = SW'(right_slot);
          child_val_next  = ram_rdata_b;
        end else begin
          child_slot_next = SW'(left_slot);
          child_val_next  = ram_rdata_a;
        end
        state_next = bmhq_pkg::ST_DN_SW;
      end
      bmhq_pkg::ST_DN_SW: begin
        cmp_a  = key;
        cmp_b  = child_val;
        ram_we = 1'b1;
        if (cmp_less) begin
          // Child moves up, key sinks one level.
          ram_wdata  = child_val;
          slot_next  = child_slot;
          state_next = bmhq_pkg::ST_DN_RD;
        end else begin
          state_next = bmhq_pkg::ST_OUT;
        end
      end
      bmhq_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = bmhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bmhq_pkg::ST_IDLE;
      count_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count_q <= count_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_idx   <= slot_next;
    child_slot <= child_slot_next;
    key        <= key_next;
    child_val  <= child_val_next;
    res_value  <= res_value_next;
    res_pop    <= res_pop_next;
    res_err    <= res_err_next;
    if (out_load) begin
      m_axis_tdata <= {bmhq_pkg::COUNT_W'(count_q), res_value};
      m_axis_tuser <= {res_err, res_pop};
    end
  end

`include "binary_max_heap_queue_unit_assert.svh"

  `BMHQ_ASSERT_NEXT(a_pop_empty_refused,
    in_req && s_axis_tuser == bmhq_pkg::ACT_POP && count_q == '0,
    state == bmhq_pkg::ST_OUT && res_err == bmhq_pkg::ERR_EMPTY && !res_pop,
    "pop on empty heap not refused")
  `BMHQ_ASSERT_NOW(a_pop_has_no_error,
    m_axis_tvalid && m_axis_tuser[0],
    m_axis_tuser[2:1] == bmhq_pkg::ERR_NONE,
    "popped result carries an error code")
  `BMHQ_ASSERT_NEXT(a_count_idle_stable,
    state == bmhq_pkg::ST_IDLE && !in_req,
    $stable(count_q),
    "entry count moved without a request")
  `BMHQ_ASSERT_NOW(a_write_in_range,
    ram_we,
    slot_idx != '0 && slot_idx <= SW'(bmhq_pkg::CAPACITY),
    "heap write outside slot range")

endmodule

`default_nettype wire
